/* sv/assert_macros.svh */
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define CUPP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("cupp check failed");

// Antecedent at one edge implies consequent at the next edge.
`define CUPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("cupp check failed");

`endif

/* sv/cupp_pkg.sv */
package cupp_pkg;

	localparam logic [31:0] SYNC_RESET = 32'hDEADBEEF;

	localparam logic [7:0] CMD_SPARSE_BYTE = 8'h01;
	localparam logic [7:0] CMD_DENSE_BYTE  = 8'h02;

	// Byte positions within a packet
	localparam logic [17:0] POS_CMD    = 18'd4;
	localparam logic [17:0] POS_STREAM = 18'd5;
	localparam logic [17:0] POS_CNT_LO = 18'd6;
	localparam logic [17:0] POS_CNT_HI = 18'd7;
	localparam logic [17:0] POS_EMPTY  = 18'd8;

	typedef enum logic [1:0] {
		EV_WRITE    = 2'd0,
		EV_EMPTY    = 2'd1,
		EV_MISMATCH = 2'd2,
		EV_BADCMD   = 2'd3
	} event_kind_t;

	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_SPARSE = 2'd1,
		CMD_DENSE  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		PH_LO  = 2'd0,
		PH_HI  = 2'd1,
		PH_VAL = 2'd2
	} phase_t;

	typedef struct packed {
		logic        emit;
		event_kind_t kind;
		logic [15:0] ch_index;
		logic [7:0]  ch_value;
		logic [7:0]  stream;
		logic        pkt_end;
		logic [16:0] extent;
		logic [17:0] pkt_bytes;
		logic [31:0] pkt_count;
		logic [17:0] max_bytes;
		logic [15:0] max_updates;
	} result_t;

endpackage

/* sv/cupp_parse.sv */
module cupp_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       rx_byte,
	input  logic             cfg_wr_en,
	input  logic [31:0]      cfg_wr_data,
	output cupp_pkg::result_t res
);
	import cupp_pkg::*;

	logic [31:0] sync_q;
	logic [17:0] pos_q, pos_d;
	cmd_t        cmd_q, cmd_d;
	logic [7:0]  stream_q, stream_d;
	logic [15:0] count_q, count_d;
	logic [17:0] left_q, left_d;
	logic [15:0] dense_q, dense_d;
	phase_t      phase_q, phase_d;
	logic [15:0] latch_q, latch_d;
	logic [16:0] extent_q, extent_d;
	logic [31:0] pkts_q, pkts_d;
	logic [17:0] largest_q, largest_d;
	logic [15:0] lupd_q, lupd_d;

	logic [7:0]  exp_byte;
	logic [15:0] cnt;
	logic [17:0] pos_inc;
	logic [15:0] ch;
	logic [16:0] ch_p1;
	logic        wr;
	logic        fin;
	logic [17:0] fin_bytes;

	always_comb begin
		unique case (pos_q[1:0])
			2'd0: exp_byte = sync_q[31:24];
			2'd1: exp_byte = sync_q[23:16];
			2'd2: exp_byte = sync_q[15:8];
			default: exp_byte = sync_q[7:0];
		endcase
	end

	assign cnt     = {rx_byte, count_q[7:0]};
	assign pos_inc = pos_q + 18'd1;
	assign ch_p1   = {1'b0, ch} + 17'd1;

	always_comb begin
		pos_d     = pos_q;
		cmd_d     = cmd_q;
		stream_d  = stream_q;
		count_d   = count_q;
		left_d    = left_q;
		dense_d   = dense_q;
		phase_d   = phase_q;
		latch_d   = latch_q;
		extent_d  = extent_q;
		pkts_d    = pkts_q;
		largest_d = largest_q;
		lupd_d    = lupd_q;
		ch        = '0;
		wr        = 1'b0;
		fin       = 1'b0;
		fin_bytes = pos_inc;
		res       = '0;

		priority if (pos_q < POS_CMD) begin
			if (rx_byte != exp_byte) begin
				// restart the hunt, keeping a byte that opens the sync word
				pos_d         = (rx_byte == sync_q[31:24]) ? 18'd1 : 18'd0;
				res.emit      = 1'b1;
				res.kind      = EV_MISMATCH;
				res.pkt_bytes = pos_d;
			end else begin
				pos_d = pos_inc;
			end
		end else if (pos_q == POS_CMD) begin
			if (rx_byte == CMD_SPARSE_BYTE || rx_byte == CMD_DENSE_BYTE) begin
				cmd_d = cmd_t'(rx_byte[1:0]);
				pos_d = pos_inc;
			end else begin
				pos_d         = '0;
				res.emit      = 1'b1;
				res.kind      = EV_BADCMD;
				res.pkt_bytes = pos_inc;
			end
		end else if (pos_q == POS_STREAM) begin
			stream_d = rx_byte;
			pos_d    = pos_inc;
		end else if (pos_q == POS_CNT_LO) begin
			count_d = {8'd0, rx_byte};
			pos_d   = pos_inc;
		end else if (pos_q == POS_CNT_HI) begin
			count_d = cnt;
			pos_d   = pos_inc;
			dense_d = '0;
			phase_d = PH_LO;
			if (cmd_q == CMD_DENSE) begin
				left_d = {2'd0, cnt};
				if (extent_q < {1'b0, cnt})
					extent_d = {1'b0, cnt};
			end else begin
				left_d = {2'd0, cnt} + {1'b0, cnt, 1'b0};
			end
			if (cnt == '0) begin
				fin           = 1'b1;
				fin_bytes     = POS_EMPTY;
				pos_d         = '0;
				res.emit      = 1'b1;
				res.kind      = EV_EMPTY;
				res.stream    = stream_q;
				res.pkt_end   = 1'b1;
				res.pkt_bytes = POS_EMPTY;
			end
		end else begin
			pos_d = pos_inc;
			if (left_q != '0)
				left_d = left_q - 18'd1;
			if (cmd_q == CMD_DENSE) begin
				ch      = dense_q;
				dense_d = dense_q + 16'd1;
				wr      = 1'b1;
			end else begin
				ch = latch_q;
				unique case (phase_q)
					PH_LO: begin
						latch_d = {8'd0, rx_byte};
						phase_d = PH_HI;
					end
					PH_HI: begin
						latch_d = {rx_byte, latch_q[7:0]};
						phase_d = PH_VAL;
					end
					default: begin
						phase_d = PH_LO;
						wr      = 1'b1;
					end
				endcase
			end
			if (wr && extent_q < ch_p1)
				extent_d = ch_p1;
			if (left_d == '0) begin
				fin   = 1'b1;
				pos_d = '0;
			end
			res.emit      = wr;
			res.kind      = EV_WRITE;
			res.ch_index  = ch;
			res.ch_value  = rx_byte;
			res.stream    = stream_q;
			res.pkt_end   = fin;
			res.pkt_bytes = pos_inc;
		end

		if (fin) begin
			if (fin_bytes > largest_q) begin
				largest_d = fin_bytes;
				lupd_d    = count_d;
			end
			pkts_d = pkts_q + 32'd1;
		end

		res.extent      = extent_d;
		res.pkt_count   = pkts_d;
		res.max_bytes   = largest_d;
		res.max_updates = lupd_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg_wr_en) begin
			sync_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			cmd_q     <= CMD_NONE;
			stream_q  <= '0;
			count_q   <= '0;
			left_q    <= '0;
			dense_q   <= '0;
			phase_q   <= PH_LO;
			latch_q   <= '0;
			extent_q  <= '0;
			pkts_q    <= '0;
			largest_q <= '0;
			lupd_q    <= '0;
		end else if (fire) begin
			pos_q     <= pos_d;
			cmd_q     <= cmd_d;
			stream_q  <= stream_d;
			count_q   <= count_d;
			left_q    <= left_d;
			dense_q   <= dense_d;
			phase_q   <= phase_d;
			latch_q   <= latch_d;
			extent_q  <= extent_d;
			pkts_q    <= pkts_d;
			largest_q <= largest_d;
			lupd_q    <= lupd_d;
		end
	end

endmodule

/* sv/channel_update_packet_parser.sv */
// Pipeline: an accepted byte is held in byte_s1 and parsed when the parse stage
// fires; its result, if any, is registered into res_s2 at that edge.
// Throughput: one byte per cycle while the result slot is free or draining; the
// parse state updates only when the parse stage fires. A stalled result holds
// the parse stage, which then stalls the input. Reset (arst_n low) clears all
// parse state and statistics and loads sync_q with 0xDEADBEEF.
module channel_update_packet_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_kind,
	output logic [15:0] channel_index,
	output logic [7:0]  channel_value,
	output logic [7:0]  stream_id,
	output logic        packet_end,
	output logic [16:0] channel_extent,
	output logic [17:0] packet_bytes,
	output logic [31:0] packet_count,
	output logic [17:0] max_packet_bytes,
	output logic [15:0] updates_at_max
);
	import cupp_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	result_t    res_s2;
	result_t    res;
	logic       fire_s1;

	// advance the parse stage when the result slot is free or being drained
	assign fire_s1  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !fire_s1;

	cupp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire_s1),
		.rx_byte    (byte_s1),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1) begin
			valid_s2 <= res.emit;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && res.emit) begin
			res_s2 <= res;
		end
	end

	assign out_valid        = valid_s2;
	assign event_kind       = res_s2.kind;
	assign channel_index    = res_s2.ch_index;
	assign channel_value    = res_s2.ch_value;
	assign stream_id        = res_s2.stream;
	assign packet_end       = res_s2.pkt_end;
	assign channel_extent   = res_s2.extent;
	assign packet_bytes     = res_s2.pkt_bytes;
	assign packet_count     = res_s2.pkt_count;
	assign max_packet_bytes = res_s2.max_bytes;
	assign updates_at_max   = res_s2.max_updates;

endmodule

/* sv/cupp_checker.sv */
`include "assert_macros.svh"

module cupp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  event_kind,
	input logic [15:0] channel_index,
	input logic [7:0]  stream_id,
	input logic        packet_end,
	input logic [17:0] packet_bytes,
	input logic [31:0] packet_count,
	input logic [17:0] max_packet_bytes
);
	import cupp_pkg::*;

	// hold a stalled beat
	`CUPP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(event_kind) && $stable(channel_index) && $stable(packet_bytes) && $stable(packet_count))

	// a mismatch restarts the hunt at position zero or one
	`CUPP_ASSERT(a_mismatch, clk, arst_n, (out_valid && event_kind == EV_MISMATCH) |-> ((packet_bytes == 18'd0 || packet_bytes == 18'd1) && stream_id == 8'd0 && !packet_end))

	// a bad command is always seen at the fifth byte
	`CUPP_ASSERT(a_badcmd, clk, arst_n, (out_valid && event_kind == EV_BADCMD) |-> (packet_bytes == 18'd5 && channel_index == 16'd0 && !packet_end))

	// an empty packet completes on its eighth byte
	`CUPP_ASSERT(a_empty, clk, arst_n, (out_valid && event_kind == EV_EMPTY) |-> (packet_end && packet_bytes == 18'd8 && max_packet_bytes != 18'd0))

endmodule

bind channel_update_packet_parser cupp_checker u_cupp_checker (.*);
